FILE: sv/easi_source_separation_core_assert.svh
// assertion macros used by the port checker file
`ifndef EASI_SOURCE_SEPARATION_CORE_ASSERT_SVH
`define EASI_SOURCE_SEPARATION_CORE_ASSERT_SVH

// implication into the next cycle, off while reset is low
`define EASI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// implication into the next cycle, checked during reset too
`define EASI_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/easi_pkg.sv
// shared types, constants and the tanh approximation of the separation core
`timescale 1ns / 1ps

package easi_pkg;

    localparam logic                KIND_WEIGHT = 1'b0;
    localparam logic                KIND_SAMPLE = 1'b1;
    localparam logic [3:0]          MU_RESET    = 4'd9;
    localparam logic signed [31:0]  W_ONE       = 32'sh0100_0000;

    typedef struct packed {
        logic               kind;
        logic [1:0]         row_index;
        logic [1:0]         col_index;
        logic signed [31:0] weight_value;
        logic signed [15:0] x0;
        logic signed [15:0] x1;
        logic signed [15:0] x2;
        logic signed [15:0] x3;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] y0;
        logic signed [15:0] y1;
        logic signed [15:0] y2;
        logic signed [15:0] y3;
        logic               sat_flag;
    } t_out_item;

    // tanh(k/4) in q4.12
    function automatic logic [11:0] tanh_point(input logic [4:0] k);
        logic [11:0] r;
        begin
            case (k)
                5'd0:  r = 12'd0;
                5'd1:  r = 12'd1003;
                5'd2:  r = 12'd1893;
                5'd3:  r = 12'd2602;
                5'd4:  r = 12'd3119;
                5'd5:  r = 12'd3475;
                5'd6:  r = 12'd3707;
                5'd7:  r = 12'd3856;
                5'd8:  r = 12'd3949;
                5'd9:  r = 12'd4006;
                5'd10: r = 12'd4041;
                5'd11: r = 12'd4062;
                5'd12: r = 12'd4076;
                5'd13: r = 12'd4084;
                5'd14: r = 12'd4089;
                5'd15: r = 12'd4091;
                default: r = 12'd4093;
            endcase
            return r;
        end
    endfunction

    // piecewise linear tanh, odd symmetric
    function automatic logic signed [15:0] tanh_q12(input logic signed [15:0] v);
        logic [16:0] a;
        logic [6:0]  idx;
        logic [9:0]  fr;
        logic [11:0] lo;
        logic [11:0] hi;
        logic [21:0] prod;
        logic [11:0] r;
        begin
            a   = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
            idx = a[16:10];
            fr  = a[9:0];
            lo  = tanh_point(idx[4:0]);
            hi  = tanh_point(idx[4:0] + 5'd1);
            prod = 22'(hi - lo) * 22'(fr);
            if (idx >= 7'd16) begin
                r = 12'd4093;
            end else begin
                r = lo + prod[21:10];
            end
            return v[15] ? (16'sd0 - $signed({4'b0, r})) : $signed({4'b0, r});
        end
    endfunction

endpackage

FILE: sv/easi_source_separation_core.sv
// easi adaptive source separation core: y = W x, then W -= 2^-mu * V * W
`timescale 1ns / 1ps

//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (mu_shift)
//
//  a weight write is taken in the idle state; a sample stalls the input until
//  it is done, paced by the single read port of the weight memory and the
//  one multiplier of the mac pipeline
//  after reset a clearing pass loads the identity matrix, input stalled meanwhile
//  the result sits in an output register, so a waiting result only holds the
//  block at the end of the following sample

module easi_source_separation_core #(
    parameter int CHANNELS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  easi_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output easi_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [3:0]           i_cfg_data
);
    import easi_pkg::*;

    localparam logic [1:0] LAST = 2'(CHANNELS - 1);
    localparam logic [2:0] KOLD = 3'(CHANNELS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_YMAC  = 7'b0000100,
        S_TANH  = 7'b0001000,
        S_VROW  = 7'b0010000,
        S_UMAC  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // tag that travels with each memory read through the mac pipeline
    typedef struct packed {
        logic       last;
        logic       old;
        logic [1:0] row;
        logic [1:0] col;
        logic [2:0] k;
    } t_tag;

    t_state             r_state;
    logic [3:0]         r_mu;
    logic               r_bank;
    logic [3:0]         r_clr;
    logic [1:0]         r_ci;
    logic [1:0]         r_cj;
    logic [2:0]         r_ck;
    logic               r_iss;
    logic               r_v1;
    logic               r_v2;
    t_tag               r_tag1;
    t_tag               r_tag2;
    logic [31:0]        r_rd;
    logic [31:0]        r_rd2;
    logic signed [63:0] r_prod;
    logic signed [59:0] r_acc;
    logic signed [15:0] r_x    [4];
    logic signed [15:0] r_y    [4];
    logic signed [15:0] r_t    [4];
    logic signed [31:0] r_vrow [4];
    logic               r_sat;
    logic               r_out_valid;
    t_out_item          r_out;

    // two banks of the matrix: a sample reads one and writes the other
    logic [31:0]        r_mem  [32];

    logic               in_acc;
    logic               w_en;
    logic [4:0]         w_addr;
    logic [31:0]        w_data;
    logic [4:0]         rd_addr;
    t_tag               iss_tag;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [59:0] add_term;
    logic signed [59:0] n_acc;
    logic signed [59:0] y_rnd;
    logic signed [15:0] y_sat;
    logic               y_ovf;
    logic signed [59:0] d_rnd;
    logic signed [59:0] w_full;
    logic signed [31:0] w_sat;
    logic               w_ovf;
    logic signed [33:0] v_yi;
    logic signed [33:0] v_ti;
    logic signed [33:0] v_yk;
    logic signed [33:0] v_ypt;
    logic signed [33:0] v_sum;
    logic [4:0]         sh_amt;

    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- weight memory ----------------
    always_comb begin
        w_en   = 1'b0;
        w_addr = {r_bank, i_in_data.row_index, i_in_data.col_index};
        w_data = i_in_data.weight_value;
        case (r_state)
            S_CLEAR: begin
                // identity into bank zero
                w_en   = 1'b1;
                w_addr = {1'b0, r_clr};
                w_data = (r_clr[3:2] == r_clr[1:0]) ? W_ONE : 32'sd0;
            end
            S_IDLE: begin
                w_en = in_acc && (i_in_data.kind == KIND_WEIGHT)
                       && (i_in_data.row_index <= LAST) && (i_in_data.col_index <= LAST);
            end
            S_UMAC: begin
                w_en   = r_v2 && r_tag2.old;
                w_addr = {~r_bank, r_ci, r_tag2.col};
                w_data = w_sat;
            end
            default: begin
                w_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        if ((r_state == S_UMAC) && (r_ck != KOLD)) begin
            rd_addr = {r_bank, r_ck[1:0], r_cj};
        end else begin
            rd_addr = {r_bank, r_ci, r_cj};
        end
        iss_tag.last = (r_cj == LAST);
        iss_tag.old  = (r_ck == KOLD);
        iss_tag.row  = r_ci;
        iss_tag.col  = r_cj;
        iss_tag.k    = r_ck;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // ---------------- multiply stage ----------------
    // row pass multiplies by x, update pass by a row of V
    always_comb begin
        op_a = $signed(r_rd);
        if (r_state == S_YMAC) begin
            op_b = 32'(r_x[r_tag1.col]);
        end else begin
            op_b = r_vrow[r_tag1.k[1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(op_a) * 64'(op_b);
        r_rd2  <= r_rd;
        r_tag2 <= r_tag1;
        r_tag1 <= iss_tag;
    end

    // ---------------- accumulate and finish ----------------
    always_comb begin
        // update products are floored by 2^8 before summing
        add_term = (r_state == S_YMAC) ? 60'(r_prod) : 60'(r_prod >>> 8);
        n_acc    = r_acc + add_term;

        // y: round half up by 2^24, saturate to q4.12
        y_rnd = (n_acc + 60'sd8388608) >>> 24;
        y_ovf = (y_rnd > 60'sd32767) || (y_rnd < -60'sd32768);
        if (y_rnd > 60'sd32767) begin
            y_sat = 16'sd32767;
        end else if (y_rnd < -60'sd32768) begin
            y_sat = -16'sd32768;
        end else begin
            y_sat = 16'(y_rnd);
        end

        // weight step: round half up by 2^(16+mu), subtract, saturate
        sh_amt = 5'd16 + {1'b0, r_mu};
        d_rnd  = (r_acc + (60'sd1 <<< (sh_amt - 5'd1))) >>> sh_amt;
        w_full = 60'($signed(r_rd2)) - d_rnd;
        w_ovf  = (w_full > 60'sd2147483647) || (w_full < -60'sd2147483648);
        if (w_full > 60'sd2147483647) begin
            w_sat = 32'sh7fff_ffff;
        end else if (w_full < -60'sd2147483648) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = 32'(w_full);
        end
    end

    // V row i: y_i (y_k + t_k) - t_i y_k - [i == k]
    always_comb begin
        v_yi  = 34'(r_y[r_ci]);
        v_ti  = 34'(r_t[r_ci]);
        v_yk  = 34'(r_y[r_ck[1:0]]);
        v_ypt = 34'(r_y[r_ck[1:0]]) + 34'(r_t[r_ck[1:0]]);
        v_sum = v_yi * v_ypt - v_ti * v_yk
                - ((r_ck[1:0] == r_ci) ? 34'sd16777216 : 34'sd0);
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= 4'd0;
            r_mu        <= MU_RESET;
            r_bank      <= 1'b0;
            r_iss       <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mu <= i_cfg_data;
            end
            // a result taken while the next one is ready is refilled below
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            r_v1 <= r_iss;
            r_v2 <= r_v1;

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 4'd1;
                    if (r_clr == 4'd15) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc && (i_in_data.kind == KIND_SAMPLE)) begin
                        r_x[0] <= i_in_data.x0;
                        r_x[1] <= i_in_data.x1;
                        r_x[2] <= i_in_data.x2;
                        r_x[3] <= i_in_data.x3;
                        for (int n = 0; n < 4; n++) begin
                            r_y[n] <= 16'sd0;
                        end
                        r_sat   <= 1'b0;
                        r_acc   <= 60'sd0;
                        r_ci    <= 2'd0;
                        r_cj    <= 2'd0;
                        r_ck    <= 3'd0;
                        r_iss   <= 1'b1;
                        r_state <= S_YMAC;
                    end
                end
                S_YMAC: begin
                    if (r_iss) begin
                        if (r_cj == LAST) begin
                            r_cj <= 2'd0;
                            if (r_ci == LAST) begin
                                r_iss <= 1'b0;
                            end else begin
                                r_ci <= r_ci + 2'd1;
                            end
                        end else begin
                            r_cj <= r_cj + 2'd1;
                        end
                    end
                    if (r_v2) begin
                        if (r_tag2.last) begin
                            r_y[r_tag2.row] <= y_sat;
                            r_sat <= r_sat | y_ovf;
                            r_acc <= 60'sd0;
                        end else begin
                            r_acc <= n_acc;
                        end
                    end
                    if (!r_iss && !r_v1 && !r_v2) begin
                        r_ci    <= 2'd0;
                        r_state <= S_TANH;
                    end
                end
                S_TANH: begin
                    r_t[r_ci] <= tanh_q12(r_y[r_ci]);
                    if (r_ci == LAST) begin
                        r_ci    <= 2'd0;
                        r_ck    <= 3'd0;
                        r_state <= S_VROW;
                    end else begin
                        r_ci <= r_ci + 2'd1;
                    end
                end
                S_VROW: begin
                    r_vrow[r_ck[1:0]] <= 32'(v_sum);
                    if (r_ck[1:0] == LAST) begin
                        r_ck    <= 3'd0;
                        r_cj    <= 2'd0;
                        r_iss   <= 1'b1;
                        r_state <= S_UMAC;
                    end else begin
                        r_ck <= r_ck + 3'd1;
                    end
                end
                S_UMAC: begin
                    // per column: CHANNELS products, then the old weight
                    if (r_iss) begin
                        if (r_ck == KOLD) begin
                            r_ck <= 3'd0;
                            if (r_cj == LAST) begin
                                r_iss <= 1'b0;
                            end else begin
                                r_cj <= r_cj + 2'd1;
                            end
                        end else begin
                            r_ck <= r_ck + 3'd1;
                        end
                    end
                    if (r_v2) begin
                        if (r_tag2.old) begin
                            r_sat <= r_sat | w_ovf;
                            r_acc <= 60'sd0;
                        end else begin
                            r_acc <= n_acc;
                        end
                    end
                    if (!r_iss && !r_v1 && !r_v2) begin
                        if (r_ci == LAST) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ci    <= r_ci + 2'd1;
                            r_ck    <= 3'd0;
                            r_state <= S_VROW;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_bank      <= ~r_bank;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && (!r_out_valid || !i_out_stall)) begin
            r_out.y0       <= r_y[0];
            r_out.y1       <= r_y[1];
            r_out.y2       <= r_y[2];
            r_out.y3       <= r_y[3];
            r_out.sat_flag <= r_sat;
        end
    end

endmodule

FILE: sv/easi_sva.sv
// port checker for the separation core and its bind
`timescale 1ns / 1ps
`include "easi_source_separation_core_assert.svh"

module easi_sva (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input easi_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input easi_pkg::t_out_item o_out_data,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [3:0]          i_cfg_data
);
    import easi_pkg::*;

    `EASI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `EASI_ASSERT_NEXT_ALWAYS(a_reset_stall, i_clk, !i_rst_n, o_in_stall, "input open right after reset")
    `EASI_ASSERT_NEXT(a_sample_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in_data.kind == KIND_SAMPLE), o_in_stall, "sample transfer not followed by busy")
    `EASI_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in_data.kind == KIND_WEIGHT) && !o_out_valid, !o_out_valid, "weight write produced a result")

endmodule

bind easi_source_separation_core easi_sva u_easi_sva (.*);

FILE: bench/easi_source_separation_core_tb.sv
// self-checking bench for the easi source separation core: random and directed transfers
`timescale 1ns / 1ps

module easi_source_separation_core_tb;
    import easi_pkg::*;

    // tanh(k/4) in q4.12, the segment ends of the interpolated curve
    localparam longint TANH_END [17] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856,
        3949, 4006, 4041, 4062, 4076, 4084, 4089, 4091, 4093};
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int DRAIN_CYCLES    = 200;
    localparam longint W_MIN       = -(longint'(1) <<< 31);

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;

    // model state: separating matrix and step gain exponent
    logic signed [31:0] sep_w [4][4];
    logic [3:0]         gain_shift;

    t_in_item  pending_q [$];
    t_out_item sep_expect_q [$];
    int        mismatches;
    int        samples_done;
    int        writes_done;
    int        sat_seen;
    int        quiet_cycles;
    bit        calm;

    easi_source_separation_core #(.CHANNELS(4)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint tanh_pwl(input longint v);
        longint a;
        longint idx;
        longint r;
        a   = (v < 0) ? -v : v;
        idx = a >> 10;
        if (idx >= 16) begin
            r = TANH_END[16];
        end else begin
            r = TANH_END[idx] + (((TANH_END[idx + 1] - TANH_END[idx]) * (a & 1023)) >> 10);
        end
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi,
                                    inout bit sat);
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        return v;
    endfunction

    // one sample: outputs from the old matrix, then the natural gradient update
    function automatic t_out_item separate_sample(input t_in_item it);
        longint x [4];
        longint y [4];
        longint t [4];
        longint v [4][4];
        logic signed [31:0] nw [4][4];
        longint acc;
        longint d;
        bit sat;
        t_out_item r;
        sat  = 1'b0;
        x[0] = it.x0;
        x[1] = it.x1;
        x[2] = it.x2;
        x[3] = it.x3;
        for (int i = 0; i < 4; i++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) acc += longint'(sep_w[i][j]) * x[j];
            y[i] = clip((acc + (longint'(1) <<< 23)) >>> 24, -32768, 32767, sat);
            t[i] = tanh_pwl(y[i]);
        end
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                v[i][j] = y[i] * y[j] - ((i == j) ? (longint'(1) <<< 24) : 0)
                          - t[i] * y[j] + y[i] * t[j];
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) acc += (v[i][k] * longint'(sep_w[k][j])) >>> 8;
                d = (acc + (longint'(1) <<< (15 + gain_shift))) >>> (16 + gain_shift);
                nw[i][j] = 32'(clip(longint'(sep_w[i][j]) - d, W_MIN, 2147483647, sat));
            end
        sep_w      = nw;
        r.y0       = 16'(y[0]);
        r.y1       = 16'(y[1]);
        r.y2       = 16'(y[2]);
        r.y3       = 16'(y[3]);
        r.sat_flag = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        mismatches++;
    endtask

    function automatic t_in_item weight_item(input int row, input int col, input longint w);
        t_in_item it;
        it              = t_in_item'({$urandom, $urandom, $urandom});
        it.kind         = KIND_WEIGHT;
        it.row_index    = 2'(row);
        it.col_index    = 2'(col);
        it.weight_value = 32'(w);
        return it;
    endfunction

    function automatic t_in_item sample_item(input longint a, input longint b,
                                             input longint c, input longint e);
        t_in_item it;
        it      = t_in_item'({$urandom, $urandom, $urandom});
        it.kind = KIND_SAMPLE;
        it.x0   = 16'(a);
        it.x1   = 16'(b);
        it.x2   = 16'(c);
        it.x3   = 16'(e);
        return it;
    endfunction

    // mostly small mixtures so the matrix keeps adapting, a few full scale inputs
    function automatic longint mix_value();
        if ($urandom_range(99) < 10) return longint'($signed(16'($urandom)));
        return longint'($urandom_range(8192)) - 4096;
    endfunction

    // input driver: a new transfer is presented only after the previous one is taken, with random idle gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: model update on input transfers, checking of output transfers
    always @(posedge i_clk) begin
        t_out_item want;
        bit        took;
        took = 1'b0;
        if (i_rst_n) begin
            i_out_stall <= !calm && ($urandom_range(99) < 17);
            if (i_cfg_valid && o_cfg_ready) begin
                gain_shift   <= i_cfg_data;
                i_cfg_valid  <= 1'b0;
                took = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                took = 1'b1;
                if (i_in_data.kind == KIND_WEIGHT) begin
                    sep_w[i_in_data.row_index][i_in_data.col_index] = i_in_data.weight_value;
                    writes_done++;
                end else begin
                    sep_expect_q.push_back(separate_sample(i_in_data));
                end
            end
            if (o_out_valid && !i_out_stall) begin
                took = 1'b1;
                if (sep_expect_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = sep_expect_q.pop_front();
                    samples_done++;
                    if (want.sat_flag) sat_seen++;
                    if (o_out_data.y0 !== want.y0) report_mismatch("y0", o_out_data.y0, want.y0);
                    if (o_out_data.y1 !== want.y1) report_mismatch("y1", o_out_data.y1, want.y1);
                    if (o_out_data.y2 !== want.y2) report_mismatch("y2", o_out_data.y2, want.y2);
                    if (o_out_data.y3 !== want.y3) report_mismatch("y3", o_out_data.y3, want.y3);
                    if (o_out_data.sat_flag !== want.sat_flag)
                        report_mismatch("sat_flag", o_out_data.sat_flag, want.sat_flag);
                end
            end
            quiet_cycles <= took ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("watchdog expired with %0d results outstanding", sep_expect_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (pending_q.size() > 0 || i_in_valid || sep_expect_q.size() > 0)
            @(posedge i_clk);
        // a trailing weight write may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_gain(input logic [3:0] m);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (i_cfg_valid) @(posedge i_clk);
    endtask

    // one phase: load a random near-identity matrix, then adapt on random mixtures with occasional weight rewrites
    task automatic run_phase(input int n_items);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                pending_q.push_back(weight_item(i, j, ((i == j) ? longint'(W_ONE) : 0)
                    + longint'($urandom_range(1 << 23)) - (1 << 22)));
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(99) < 12) begin
                // noise: occasional rewrites with any value
                pending_q.push_back(weight_item($urandom_range(3), $urandom_range(3),
                    ($urandom_range(3) == 0) ? longint'($signed($urandom))
                                             : longint'($urandom_range(1 << 26)) - (1 << 25)));
            end else begin
                pending_q.push_back(sample_item(mix_value(), mix_value(), mix_value(),
                                                mix_value()));
            end
        end
        wait_idle();
    endtask

    initial begin
        logic [3:0] gains [5];
        gains        = '{4'd15, 4'd0, 4'd9, 4'd4, 4'd12};
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        mismatches   = 0;
        samples_done = 0;
        writes_done  = 0;
        sat_seen     = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        gain_shift   = MU_RESET;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                sep_w[i][j] = (i == j) ? W_ONE : 32'sd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset gain and identity matrix, extremes of inputs and weights
        pending_q.push_back(sample_item(0, 0, 0, 0));
        pending_q.push_back(sample_item(32767, 32767, 32767, 32767));
        pending_q.push_back(sample_item(-32768, -32768, -32768, -32768));
        pending_q.push_back(sample_item(4096, -4096, 1024, -1023));
        pending_q.push_back(sample_item(16384, -16385, 1, -1));
        pending_q.push_back(weight_item(0, 0, 2147483647));
        pending_q.push_back(weight_item(3, 3, W_MIN));
        pending_q.push_back(weight_item(1, 2, 0));
        pending_q.push_back(weight_item(2, 1, -1));
        // saturating outputs and weights
        pending_q.push_back(sample_item(32767, -32768, 32767, -32768));
        pending_q.push_back(sample_item(-1, 1, 32767, 0));
        wait_idle();

        // gain extremes and mid values, with a stretch free of idling
        for (int p = 0; p < 5; p++) begin
            set_gain(gains[p]);
            calm = (p == 2);
            run_phase(110);
        end
        calm = 1'b0;

        $display("covered %0d samples and %0d weight writes over five gain settings",
                 samples_done, writes_done);
        $display("%0d samples saturated, %0d mismatches", sat_seen, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
